@@ hw/rtl/assert_macros.svh @@
// assertion helpers shared by the rtl files
// each macro expects a clock named clk and a reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ACRS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ACRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/acrs_pkg.sv @@
// ----------------------------------------------------------------------------
// acrs_pkg
// types, codes and constants for the adc channel request scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package acrs_pkg;

  localparam int ADC_CHANNELS = 9;   // default channel count
  localparam int CH_W         = 4;   // channel number width, up to 16 channels
  localparam int PIN_W        = 5;
  localparam int SAMPLE_W     = 10;
  localparam int REF_W        = 2;
  localparam int MUX_CH_W     = 6;   // reference code sits above this field
  localparam int MUX_W        = REF_W + MUX_CH_W;
  localparam int STATUS_W     = 2;

  localparam logic [PIN_W-1:0] PIN_ALIAS = 5'd14;  // pins from here alias down
  localparam logic [REF_W-1:0] REF_RESET = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_PROGRESS = 2'd0;
  localparam logic [STATUS_W-1:0] ST_READY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADPIN   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_HANDLED  = 2'd3;

  // item kinds
  localparam logic FUNC_READ     = 1'b0;
  localparam logic FUNC_COMPLETE = 1'b1;

  // round-robin search result
  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] channel;
  } pick_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/acrs_value_mem.sv @@
// ----------------------------------------------------------------------------
// acrs_value_mem
// sample store, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module acrs_value_mem #(
  parameter int DEPTH = acrs_pkg::ADC_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [$clog2(DEPTH)-1:0]      waddr,
  input  wire logic [acrs_pkg::SAMPLE_W-1:0] wdata,
  input  wire logic                          re,
  input  wire logic [$clog2(DEPTH)-1:0]      raddr,
  output logic      [acrs_pkg::SAMPLE_W-1:0] rdata
);
  import acrs_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/acrs_rr_pick.sv @@
// ----------------------------------------------------------------------------
// acrs_rr_pick
// round-robin pick of the next pending channel after a given channel
// ----------------------------------------------------------------------------
`default_nettype none

module acrs_rr_pick #(
  parameter int CHANNELS = acrs_pkg::ADC_CHANNELS
) (
  input  wire logic [CHANNELS-1:0]       cand,
  input  wire logic [acrs_pkg::CH_W-1:0] from,
  output acrs_pkg::pick_t                pick
);
  import acrs_pkg::*;

  logic            hi_found;
  logic            lo_found;
  logic [CH_W-1:0] hi_ch;
  logic [CH_W-1:0] lo_ch;

  // lowest candidate above the start point wins, else lowest overall
  always_comb begin
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_ch    = '0;
    lo_ch    = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        lo_found = 1'b1;
        lo_ch    = CH_W'(i);
        if (CH_W'(i) > from) begin
          hi_found = 1'b1;
          hi_ch    = CH_W'(i);
        end
      end
    end
    pick.found   = hi_found | lo_found;
    pick.channel = hi_found ? hi_ch : lo_ch;
  end

endmodule

`default_nettype wire

@@ hw/rtl/adc_channel_request_scheduler.sv @@
// ----------------------------------------------------------------------------
// adc_channel_request_scheduler
// round-robin scheduler of converter channel read requests
//
// Each channel has an entry that is idle, pending or done; finished samples
// live in a small synchronous sample memory. A read beat (func 0) folds pins
// 14 and up down by 14: an idle channel becomes pending and, when the
// converter is free, a conversion is started on it (start_conversion with
// mux_setting = reference_select above the channel number); a done channel
// returns its sample and goes idle; a pending channel reports in progress;
// a folded pin outside the channel range reports bad pin and changes
// nothing. A completion beat (func 1) stores its sample for the active
// channel and restarts the converter on the next pending channel in
// round-robin order, or frees the converter; it is ignored when the
// converter is not busy. Every input beat gives exactly one result beat.
// An item is accepted and then executed: the accept cycle issues the sample
// memory read, and the execute step updates the entry state, writes the
// memory and loads the output register. The next item is accepted only after
// the execute step has committed, so the block holds no more than one item at
// a time; a result left waiting in the output register holds the execute
// step of the following item. There is no clearing pass after reset;
// reference_select may be written at any time through cfg_write/cfg_data.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module adc_channel_request_scheduler #(
  parameter int CHANNELS = acrs_pkg::ADC_CHANNELS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_write,
  input  wire logic [acrs_pkg::REF_W-1:0]    cfg_data,
  // input beats
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          func,
  input  wire logic [acrs_pkg::PIN_W-1:0]    pin,
  input  wire logic [acrs_pkg::SAMPLE_W-1:0] sample,
  // result beats
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [acrs_pkg::STATUS_W-1:0] status,
  output logic      [acrs_pkg::SAMPLE_W-1:0] value,
  output logic                               start_conversion,
  output logic      [acrs_pkg::MUX_W-1:0]    mux_setting
);
  import acrs_pkg::*;

  localparam int AW = $clog2(CHANNELS);

  // control state
  state_t              state;
  state_t              state_next;
  logic [REF_W-1:0]    reference_select;
  logic [CHANNELS-1:0] pending;
  logic [CHANNELS-1:0] done;
  logic                busy;
  logic [CH_W-1:0]     active;

  // next values, applied when the item commits
  logic [CHANNELS-1:0] pending_next;
  logic [CHANNELS-1:0] done_next;
  logic                busy_next;
  logic [CH_W-1:0]     active_next;

  // latched item
  logic                func_q;
  logic [CH_W-1:0]     ch_q;
  logic                bad_q;
  logic [SAMPLE_W-1:0] sample_q;

  // pin folding on the incoming beat
  logic [PIN_W-1:0]    pin_fold;
  logic                bad_in;
  logic                accept;

  // execute stage
  logic                commit;
  logic [CH_W-1:0]     act_fix;
  logic [CHANNELS-1:0] act_oh;
  logic [CHANNELS-1:0] cand;
  pick_t               pick;
  logic [SAMPLE_W-1:0] mem_rdata;
  logic                mem_we;
  logic [STATUS_W-1:0] status_next;
  logic [SAMPLE_W-1:0] value_next;
  logic                start_next;
  logic [CH_W-1:0]     start_ch;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;
  assign pin_fold = (pin >= PIN_ALIAS) ? (pin - PIN_ALIAS) : pin;
  assign bad_in   = ({1'b0, pin_fold} >= (PIN_W + 1)'(CHANNELS));

  // output register free, or emptied this cycle
  assign commit = (state == S_EXEC) & (~out_valid | out_ready);

  // reference register
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_select <= REF_RESET;
    end else if (cfg_write) begin
      reference_select <= cfg_data;
    end
  end

  // two-step sequencer: accept and read, then execute and write back
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      ch_q     <= pin_fold[CH_W-1:0];
      bad_q    <= bad_in;
      sample_q <= sample;
    end
  end

  // sample memory; the state machine keeps the next read behind the write,
  // so no forwarding is needed
  acrs_value_mem #(
    .DEPTH (CHANNELS)
  ) u_value_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (act_fix[AW-1:0]),
    .wdata (sample_q),
    .re    (accept),
    .raddr (pin_fold[AW-1:0]),
    .rdata (mem_rdata)
  );

  // active channel is never out of range, but fall back to channel zero
  assign act_fix = ({1'b0, active} >= (CH_W + 1)'(CHANNELS)) ? '0 : active;
  assign act_oh  = {{(CHANNELS - 1){1'b0}}, 1'b1} << act_fix;
  // the finishing channel turns done, so it drops out of the search
  assign cand    = pending & ~act_oh;

  acrs_rr_pick #(
    .CHANNELS (CHANNELS)
  ) u_rr_pick (
    .cand (cand),
    .from (act_fix),
    .pick (pick)
  );

  always_comb begin
    pending_next = pending;
    done_next    = done;
    busy_next    = busy;
    active_next  = active;
    mem_we       = 1'b0;
    status_next  = ST_PROGRESS;
    value_next   = '0;
    start_next   = 1'b0;
    start_ch     = '0;
    case (func_q)
      FUNC_READ: begin
        if (bad_q) begin
          status_next = ST_BADPIN;
        end else if (done[ch_q[AW-1:0]]) begin
          // finished sample handed back, entry freed
          status_next              = ST_READY;
          value_next               = mem_rdata;
          done_next[ch_q[AW-1:0]]  = 1'b0;
        end else if (!pending[ch_q[AW-1:0]]) begin
          pending_next[ch_q[AW-1:0]] = 1'b1;
          if (!busy) begin
            busy_next   = 1'b1;
            active_next = ch_q;
            start_next  = 1'b1;
            start_ch    = ch_q;
          end
        end
      end
      FUNC_COMPLETE: begin
        status_next = ST_HANDLED;
        if (busy) begin
          mem_we                        = 1'b1;
          done_next[act_fix[AW-1:0]]    = 1'b1;
          pending_next[act_fix[AW-1:0]] = 1'b0;
          if (pick.found) begin
            active_next = pick.channel;
            start_next  = 1'b1;
            start_ch    = pick.channel;
          end else begin
            active_next = act_fix;
            busy_next   = 1'b0;
          end
        end
      end
      default: status_next = ST_PROGRESS;
    endcase
    // writes only land with the commit of the item
    mem_we = mem_we & commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      done    <= '0;
      busy    <= 1'b0;
      active  <= '0;
    end else if (commit) begin
      pending <= pending_next;
      done    <= done_next;
      busy    <= busy_next;
      active  <= active_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      status           <= status_next;
      value            <= value_next;
      start_conversion <= start_next;
      mux_setting      <= start_next ?
                          {reference_select, {(MUX_CH_W - CH_W){1'b0}}, start_ch} : '0;
    end
  end

  // an entry is never pending and done at once
  `ACRS_ASSERT_IMPL(a_tag_exclusive, 1'b1, (pending & done) == '0,
                    "entry both pending and done")
  // while converting, the active channel is still pending
  `ACRS_ASSERT_IMPL(a_active_pending, busy, pending[active[AW-1:0]],
                    "active channel not pending while busy")
  // a started conversion shows up as a busy converter
  `ACRS_ASSERT_IMPL(a_start_busy, out_valid && start_conversion, busy,
                    "conversion started but converter not busy")
  // an accepted item moves on to the execute step
  `ACRS_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC && !in_ready,
                    "accepted item did not enter execute")

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the adc channel request scheduler
//
// Read and completion beats go in through the valid/ready input channel. An
// in-bench scheduler model predicts every result beat, and each result beat
// is checked field by field against the oldest prediction. A directed part
// covers bad pins, pin aliasing, reads while busy, ignored completions and
// the round-robin wrap. A reference part visits every reference code. The
// random part then runs under four idling phases: no idling, sender idle,
// receiver stalling, and both at a light rate.
// ----------------------------------------------------------------------------

module testbench;
  import acrs_pkg::*;

  // channel entry tags held by the scheduler model
  typedef enum logic [1:0] {
    CH_IDLE    = 2'd0,
    CH_PENDING = 2'd1,
    CH_DONE    = 2'd2
  } ch_tag_t;

  // idling phases for the two channels
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SAMPLE_W-1:0] value;
    logic                start;
    logic [MUX_W-1:0]    mux;
  } sched_result_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic [REF_W-1:0]    cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic                func      = FUNC_READ;
  logic [PIN_W-1:0]    pin       = '0;
  logic [SAMPLE_W-1:0] sample    = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SAMPLE_W-1:0] value;
  logic                start_conversion;
  logic [MUX_W-1:0]    mux_setting;

  adc_channel_request_scheduler uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .func             (func),
    .pin              (pin),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .value            (value),
    .start_conversion (start_conversion),
    .mux_setting      (mux_setting)
  );

  // scheduler model state, same reset as the block
  ch_tag_t             chan_tag    [ADC_CHANNELS] = '{default: CH_IDLE};
  logic [SAMPLE_W-1:0] chan_sample [ADC_CHANNELS] = '{default: '0};
  int unsigned         conv_channel = 0;
  bit                  conv_busy    = 1'b0;
  logic [REF_W-1:0]    ref_code     = REF_RESET;

  sched_result_t awaited_results[$];
  int            error_count = 0;
  idle_mode_t    idle_mode   = IDLE_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or drops a beat
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  // scheduler model: one result per input beat, state updated in place
  function automatic sched_result_t scheduler_outcome(input logic f,
                                                      input logic [PIN_W-1:0] p,
                                                      input logic [SAMPLE_W-1:0] s);
    sched_result_t r;
    int unsigned   ch;
    int unsigned   nxt;
    bit            found;
    r = '0;
    if (f == FUNC_READ) begin
      ch = p;
      // pins from 14 up alias onto the low channels
      if (ch >= PIN_ALIAS) ch = ch - PIN_ALIAS;
      if (ch >= ADC_CHANNELS) begin
        r.status = ST_BADPIN;
        return r;
      end
      r.status = ST_PROGRESS;
      case (chan_tag[ch])
        CH_DONE: begin
          r.status = ST_READY;
          r.value = chan_sample[ch];
          chan_tag[ch] = CH_IDLE;
        end
        CH_PENDING: begin
        end
        default: begin
          chan_tag[ch] = CH_PENDING;
          if (!conv_busy) begin
            conv_busy = 1'b1;
            conv_channel = ch;
            r.start = 1'b1;
            r.mux = {ref_code, MUX_CH_W'(ch)};
          end
        end
      endcase
    end else begin
      r.status = ST_HANDLED;
      // a completion with the converter free changes nothing
      if (conv_busy) begin
        chan_sample[conv_channel] = s;
        chan_tag[conv_channel] = CH_DONE;
        found = 1'b0;
        nxt = conv_channel;
        for (int k = 0; k < ADC_CHANNELS; k++) begin
          if (!found) begin
            nxt = (nxt + 1 >= ADC_CHANNELS) ? 0 : nxt + 1;
            if (chan_tag[nxt] == CH_PENDING) found = 1'b1;
          end
        end
        if (found) begin
          conv_channel = nxt;
          r.start = 1'b1;
          r.mux = {ref_code, MUX_CH_W'(nxt)};
        end else begin
          conv_busy = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // receiver side: out_ready stalls at the rate of the current phase
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= ($urandom_range(99) >= 76);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 12);
      default:   out_ready <= 1'b1;
    endcase
  end

  // result checker: every accepted result beat against the oldest prediction
  always @(posedge clk) begin
    sched_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0d value %0d", status, value);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          error_count++;
        end
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value);
          error_count++;
        end
        if (start_conversion !== want.start) begin
          $error("start_conversion: expected %0d, got %0d", want.start, start_conversion);
          error_count++;
        end
        if (mux_setting !== want.mux) begin
          $error("mux_setting: expected 'h%02h, got 'h%02h", want.mux, mux_setting);
          error_count++;
        end
      end
    end
  end

  // one input beat; called on a clock edge, returns on one
  task automatic send_item(input logic f, input logic [PIN_W-1:0] p,
                           input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    int unsigned pct;
    in_valid <= 1'b1;
    func     <= f;
    pin      <= p;
    sample   <= s;
    do @(posedge clk); while (!in_ready);
    awaited_results.push_back(scheduler_outcome(f, p, s));
    // sender gap after the beat, valid held low across it
    pct = (idle_mode == IDLE_SEND) ? 76 : (idle_mode == IDLE_BOTH) ? 12 : 0;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // let every awaited result arrive, then a short tail for the pipeline
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reference(input logic [REF_W-1:0] code);
    cfg_write <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    cfg_write <= 1'b0;
    ref_code = code;
  endtask

  task automatic test_directed_cases();
    idle_mode = IDLE_NONE;
    send_item(FUNC_READ, 5'd0, 10'd0);         // idle channel, converter free: starts
    send_item(FUNC_READ, 5'd14, 10'h3ff);      // alias of channel 0, already pending
    send_item(FUNC_READ, 5'd9, 10'h3ff);       // lowest bad pin
    send_item(FUNC_READ, 5'd13, 10'd0);        // highest bad pin below the alias
    send_item(FUNC_READ, 5'd31, 10'h3ff);      // folds past the top channel
    send_item(FUNC_READ, 5'd22, 10'd0);        // channel 8 while busy: pending only
    send_item(FUNC_READ, 5'd3, 10'h155);       // channel 3 pending
    send_item(FUNC_COMPLETE, 5'd0, 10'h3ff);   // channel 0 done, restart on 3
    send_item(FUNC_COMPLETE, 5'd31, 10'd0);    // channel 3 done, restart on 8
    send_item(FUNC_COMPLETE, 5'd0, 10'h155);   // channel 8 done, none pending: free
    send_item(FUNC_COMPLETE, 5'd7, 10'h2aa);   // converter free: ignored
    send_item(FUNC_READ, 5'd14, 10'd0);        // channel 0 ready
    send_item(FUNC_READ, 5'd3, 10'd0);         // channel 3 ready, zero sample
    send_item(FUNC_READ, 5'd22, 10'd0);        // channel 8 ready
    send_item(FUNC_READ, 5'd8, 10'd0);         // idle again: starts channel 8
    send_item(FUNC_READ, 5'd1, 10'd0);
    send_item(FUNC_READ, 5'd0, 10'd0);
    send_item(FUNC_COMPLETE, 5'd0, 10'h001);   // search wraps from 8 to 0
    send_item(FUNC_COMPLETE, 5'd0, 10'h200);   // on to channel 1
    send_item(FUNC_COMPLETE, 5'd0, 10'h3fe);   // nothing left: converter free
    send_item(FUNC_READ, 5'd8, 10'd0);
    send_item(FUNC_READ, 5'd0, 10'd0);
    send_item(FUNC_READ, 5'd15, 10'd0);        // alias of channel 1
    drain_results();
  endtask

  // every reference code reaches the mux field, both on a read and a restart
  task automatic test_reference_codes();
    logic [REF_W-1:0] codes [4] = '{2'd0, 2'd3, 2'd2, 2'd1};
    foreach (codes[i]) begin
      write_reference(codes[i]);
      send_item(FUNC_READ, 5'd8, 10'd0);
      send_item(FUNC_READ, PIN_W'(codes[i]), 10'd0);
      send_item(FUNC_COMPLETE, 5'd0, 10'h0f0);
      send_item(FUNC_COMPLETE, 5'd0, 10'h30f);
      send_item(FUNC_READ, 5'd22, 10'd0);
      send_item(FUNC_READ, PIN_W'(codes[i]) + PIN_ALIAS, 10'd0);
      drain_results();
    end
  endtask

  // mostly valid pins and completions while busy, a little noise
  task automatic send_random_item();
    logic                f;
    logic [PIN_W-1:0]    p;
    logic [SAMPLE_W-1:0] s;
    int unsigned         roll;
    roll = $urandom_range(99);
    if (roll < 8)
      p = $urandom_range(1) ? $urandom_range(13, 9) : $urandom_range(31, 23);
    else
      p = $urandom_range(ADC_CHANNELS - 1) + ($urandom_range(1) ? PIN_ALIAS : 0);
    f = ($urandom_range(99) < (conv_busy ? 45 : 8)) ? FUNC_COMPLETE : FUNC_READ;
    roll = $urandom_range(9);
    s = (roll == 0) ? '0 : (roll == 1) ? '1 : SAMPLE_W'($urandom_range(1023));
    send_item(f, p, s);
  endtask

  task automatic test_random_traffic();
    idle_mode_t       modes [4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    logic [REF_W-1:0] codes [4] = '{2'd3, 2'd0, 2'd2, 2'd1};
    foreach (modes[m]) begin
      drain_results();
      write_reference(codes[m]);
      idle_mode = modes[m];
      repeat (425) send_random_item();
    end
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_reference_codes();
    test_random_traffic();
    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
